/* design/sha_pkg.sv */
// sha-256 digest unit package: payload structs, constants, round functions
// no dependencies
`default_nettype none
package sha_pkg;

  localparam int LengthCountBits = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // controller to datapath
  typedef struct packed {
    logic       load_iv;      // load initial hash values
    logic       wr_byte;      // write byte into block buffer
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       start_blk;    // load a..h from hash words
    logic       round_en;     // run one round
    logic [5:0] round;
    logic       finish_blk;   // add a..h into hash words
    logic       put_len;      // overwrite the length bytes
    logic       rot_hash;     // shift digest words out
  } sha_cmd_t;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
    rotr = (x >> s) | (x << (32 - s));
  endfunction

endpackage
`default_nettype wire

/* design/sha_ctrl.sv */
// sha-256 controller: input handshake, byte count, padding sequence, rounds
// depends on sha_pkg
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
#(
  parameter int LENGTH_COUNT_BITS = LengthCountBits
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sha_in_t                       in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_idx,
  output sha_cmd_t                           cmd,
  output logic [LENGTH_COUNT_BITS-1:0]       bit_len
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RUN   = 7'b0000010,
    S_DONE  = 7'b0000100,
    S_PAD   = 7'b0001000,
    S_ZERO  = 7'b0010000,
    S_LEN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [LENGTH_COUNT_BITS-4:0] cnt_r, cnt_nxt;   // byte count, wraps with bit length
  logic [5:0] rnd_r, rnd_nxt;
  logic [5:0] ptr_r, ptr_nxt;                     // pad write pointer
  logic       closing_r, closing_nxt;             // message closes after block
  logic       xblk_r, xblk_nxt;                   // pad spilled, length goes in one more block
  logic       final_r, final_nxt;                 // running the length block
  logic [2:0] oidx_r, oidx_nxt;
  logic       acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = oidx_r;
  assign acc       = in_valid && in_ready;
  assign bit_len   = {cnt_r, 3'b000};

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rnd_nxt     = rnd_r;
    ptr_nxt     = ptr_r;
    closing_nxt = closing_r;
    xblk_nxt    = xblk_r;
    final_nxt   = final_r;
    oidx_nxt    = oidx_r;
    cmd         = '0;
    cmd.round   = rnd_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          closing_nxt = in_data.last_of_message;
          ptr_nxt     = cnt_r[5:0];
          if (in_data.byte_valid) begin
            cmd.wr_byte = 1'b1;
            cmd.wr_addr = cnt_r[5:0];
            cmd.wr_data = in_data.data_byte;
            cnt_nxt     = cnt_r + (LENGTH_COUNT_BITS-3)'(1);
            ptr_nxt     = cnt_r[5:0] + 6'd1;
          end
          if (in_data.byte_valid && cnt_r[5:0] == 6'd63) begin
            cmd.start_blk = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = S_RUN;
          end else if (in_data.last_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_RUN: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish_blk = 1'b1;
        if (final_r) begin
          final_nxt = 1'b0;
          oidx_nxt  = '0;
          state_nxt = S_OUT;
        end else if (xblk_r) begin
          // fresh block of zeros for the length
          xblk_nxt  = 1'b0;
          ptr_nxt   = '0;
          state_nxt = S_ZERO;
        end else if (closing_r) begin
          ptr_nxt   = cnt_r[5:0];
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        // pad byte at the current position, past 55 the length needs one more block
        cmd.wr_byte = 1'b1;
        cmd.wr_addr = ptr_r;
        cmd.wr_data = PadByte;
        closing_nxt = 1'b0;
        xblk_nxt    = (ptr_r >= LenPos);
        ptr_nxt     = ptr_r + 6'd1;
        if (ptr_r == 6'd63) begin
          cmd.start_blk = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = S_RUN;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.wr_byte = 1'b1;
        cmd.wr_addr = ptr_r;
        cmd.wr_data = 8'h00;
        ptr_nxt     = ptr_r + 6'd1;
        if (ptr_r == 6'd63) begin
          if (xblk_r) begin
            cmd.start_blk = 1'b1;
            rnd_nxt       = '0;
            state_nxt     = S_RUN;
          end else begin
            state_nxt = S_LEN;
          end
        end
      end
      S_LEN: begin
        // length bytes go over positions 56..63
        cmd.put_len = 1'b1;
        state_nxt   = S_RUN;
        cmd.start_blk = 1'b1;
        rnd_nxt     = '0;
        final_nxt   = 1'b1;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.rot_hash = 1'b1;
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cmd.load_iv = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      rnd_r     <= '0;
      ptr_r     <= '0;
      closing_r <= 1'b0;
      xblk_r    <= 1'b0;
      final_r   <= 1'b0;
      oidx_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rnd_r     <= rnd_nxt;
      ptr_r     <= ptr_nxt;
      closing_r <= closing_nxt;
      xblk_r    <= xblk_nxt;
      final_r   <= final_nxt;
      oidx_r    <= oidx_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/sha_dp.sv */
// sha-256 datapath: block buffer, schedule window, round logic, hash words
// depends on sha_pkg
`default_nettype none
module sha_dp
  import sha_pkg::*;
#(
  parameter int LENGTH_COUNT_BITS = LengthCountBits
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sha_cmd_t                      cmd,
  input  wire logic [LENGTH_COUNT_BITS-1:0]  bit_len,
  output logic [31:0]                        digest
);

  logic [31:0] blk_r [16];   // block buffer, first byte of each word in bits 31:24
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [63:0] len64;
  logic [31:0] w, s0, s1, t1, t2;
  logic [3:0]  wi;

  assign len64  = 64'(bit_len);
  assign digest = h_r[0];
  assign wi     = cmd.round[3:0];

  always_comb begin
    s1 = rotr(w_r[4'(wi + 4'd14)], 17) ^ rotr(w_r[4'(wi + 4'd14)], 19)
       ^ (w_r[4'(wi + 4'd14)] >> 10);
    s0 = rotr(w_r[4'(wi + 4'd1)], 7) ^ rotr(w_r[4'(wi + 4'd1)], 18)
       ^ (w_r[4'(wi + 4'd1)] >> 3);
    if (cmd.round < 6'd16)
      w = blk_r[wi];
    else
      w = s1 + w_r[4'(wi + 4'd9)] + s0 + w_r[wi];
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + RoundK[cmd.round] + w;
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte)
      blk_r[cmd.wr_addr[5:2]][{~cmd.wr_addr[1:0], 3'b000} +: 8] <= cmd.wr_data;
    if (cmd.put_len) begin
      blk_r[14] <= len64[63:32];
      blk_r[15] <= len64[31:0];
    end
    if (cmd.round_en) w_r[wi] <= w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= HashInit[i];
        v_r[i] <= '0;
      end
    end else begin
      if (cmd.load_iv) begin
        for (int i = 0; i < 8; i++) h_r[i] <= HashInit[i];
      end else if (cmd.rot_hash) begin
        for (int i = 0; i < 7; i++) h_r[i] <= h_r[i+1];
        h_r[7] <= h_r[0];
      end else if (cmd.finish_blk) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.start_blk) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end else if (cmd.round_en) begin
        v_r[0] <= t1 + t2;
        v_r[1] <= v_r[0];
        v_r[2] <= v_r[1];
        v_r[3] <= v_r[2];
        v_r[4] <= v_r[3] + t1;
        v_r[5] <= v_r[4];
        v_r[6] <= v_r[5];
        v_r[7] <= v_r[6];
      end
    end
  end

endmodule
`default_nettype wire

/* design/sha256_message_digest_unit.sv */
// sha-256 digest unit top level: controller plus datapath
// depends on sha_pkg, sha_ctrl, sha_dp
//
// channel | dir | payload   | handshake
// in      | in  | sha_in_t  | in_valid / in_ready
// out     | out | sha_out_t | out_valid / out_ready
//
// bytes are taken one per cycle while idle; the 64th byte of a block holds the
// input while the block runs: 64 rounds at one per cycle, then the hash add.
// a closing word at block position p leads to pad, zero sweep, length and one
// block, or when p >= 56 to a pad block, full zero sweep and length block; one
// more block if it also fills a block, then eight digest words.
// reset is synchronous; input stalls outside idle: blocks, padding, word output.
`default_nettype none
module sha256_message_digest_unit
  import sha_pkg::*;
#(
  parameter int LENGTH_COUNT_BITS = LengthCountBits
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sha_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sha_out_t      out_data
);

  sha_cmd_t cmd;
  logic [LENGTH_COUNT_BITS-1:0] bit_len;
  logic [2:0]  idx;
  logic [31:0] digest;

  sha_ctrl #(.LENGTH_COUNT_BITS(LENGTH_COUNT_BITS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_idx(idx), .cmd, .bit_len
  );

  sha_dp #(.LENGTH_COUNT_BITS(LENGTH_COUNT_BITS)) u_dp (
    .clk, .rst_n, .cmd, .bit_len, .digest
  );

  assign out_data.digest_word = digest;
  assign out_data.word_index  = idx;
  assign out_data.last_word   = (idx == 3'd7);

endmodule
`default_nettype wire

/* design/sha_chk.sv */
// port checker for the sha-256 digest unit, bound to the top level
// depends on sha_pkg
`default_nettype none
module sha_chk
  import sha_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire sha_out_t out_data
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input open while words go out");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last flag mismatch");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.word_index != 3'd7) |=>
    (out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1))
    else $error("word index skipped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output changed under stall");

endmodule

bind sha256_message_digest_unit sha_chk u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
